// ----- rtl/aik_pkg.sv -----
// Shared types, widths, constants and the arctangent table for the arm
// inverse kinematics block. No dependencies.
package aik_pkg;

   // geometry and iteration settings
   localparam int COORD_FRAC_BITS = 4;
   localparam int CORDIC_STEPS    = 16;
   localparam int TAB_LEN         = 24;
   localparam int CORDIC_N        = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
   localparam int STEP_W          = $clog2(TAB_LEN);

   // field widths
   localparam int COORD_W = 14;
   localparam int DEG_W   = 8;
   localparam int REACH_W = 10;
   localparam int CMD_W   = 2;

   // datapath widths
   localparam int SUM_W   = 2 * COORD_W;
   localparam int RR_W    = REACH_W + COORD_FRAC_BITS;
   localparam int RR2_W   = 2 * RR_W;
   localparam int RAD_W   = ((RR2_W > SUM_W) ? RR2_W : SUM_W) + 16;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int CV_W    = 34;
   localparam int PHASE_W = 33;
   localparam int S_W     = PHASE_W + 1;
   localparam int NUM_W   = 56;
   localparam int Q_SHIFT = 30;
   localparam int QUO_W   = NUM_W - Q_SHIFT;
   localparam int REM_W   = 21;
   localparam int DSTEP_W = 3;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // constants
   localparam logic [REACH_W-1:0] REACH_RESET  = 10'd160;
   localparam logic [DEG_W-1:0]   ANGLE_CENTER = 8'd90;
   localparam logic [DEG_W-1:0]   ANGLE_MAX    = 8'd180;
   localparam logic signed [PHASE_W-1:0] HALF_PI = 33'sd1686629713;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TARGET = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GRIP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]          kind;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [DEG_W-1:0]          grip;
   } item_type;

   typedef struct packed {
      logic [DEG_W-1:0] base;
      logic [DEG_W-1:0] shoulder;
      logic [DEG_W-1:0] elbow;
      logic [DEG_W-1:0] grip;
      logic             unreachable;
      logic             settled;
   } result_type;

   // atan(2^-i) in radians, 30 fraction bits
   function automatic logic signed [PHASE_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic signed [PHASE_W-1:0] v;
      case (idx)
         5'd0:  v = 33'sd843314857;
         5'd1:  v = 33'sd497837830;
         5'd2:  v = 33'sd263043837;
         5'd3:  v = 33'sd133525159;
         5'd4:  v = 33'sd67021687;
         5'd5:  v = 33'sd33543516;
         5'd6:  v = 33'sd16775851;
         5'd7:  v = 33'sd8388437;
         5'd8:  v = 33'sd4194283;
         5'd9:  v = 33'sd2097149;
         5'd10: v = 33'sd1048576;
         5'd11: v = 33'sd524288;
         5'd12: v = 33'sd262144;
         5'd13: v = 33'sd131072;
         5'd14: v = 33'sd65536;
         5'd15: v = 33'sd32768;
         5'd16: v = 33'sd16384;
         5'd17: v = 33'sd8192;
         5'd18: v = 33'sd4096;
         5'd19: v = 33'sd2048;
         5'd20: v = 33'sd1024;
         5'd21: v = 33'sd512;
         5'd22: v = 33'sd256;
         5'd23: v = 33'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/aik_front.sv -----
// Input side: accepts items, classifies them and holds them in a short queue.
// Depends on aik_pkg.
module aik_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [aik_pkg::CMD_W-1:0]     command,
   input  logic signed [aik_pkg::COORD_W-1:0] coord_x,
   input  logic signed [aik_pkg::COORD_W-1:0] coord_y,
   input  logic signed [aik_pkg::COORD_W-1:0] coord_z,
   input  logic [aik_pkg::DEG_W-1:0]     gripper_target,
   output logic                          head_valid,
   output aik_pkg::item_type             head,
   input  logic                          head_pop
);
   import aik_pkg::*;

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   item_type            item;
   logic                do_push, do_pop;

   // classify: command code and saturated gripper angle
   always_comb begin
      item.kind = command;
      item.x    = coord_x;
      item.y    = coord_y;
      item.z    = coord_z;
      item.grip = (gripper_target > ANGLE_MAX) ? ANGLE_MAX : gripper_target;
   end

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = head_pop && head_valid;

   // pointers wrap naturally, depth is a power of two
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ----- rtl/aik_isqrt.sv -----
// Iterative integer square root, two operand bits per cycle.
// Depends on aik_pkg.
module aik_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [aik_pkg::RAD_W-1:0]   operand,
   output logic                        done,
   output logic [aik_pkg::ROOT_W-1:0]  root
);
   import aik_pkg::*;

   localparam logic [RAD_W-1:0] TOP_BIT = RAD_W'(1) << (RAD_W - 2);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RAD_W-1:0] rem_ff, rem_in;
   logic [RAD_W-1:0] res_ff, res_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic [RAD_W-1:0] trial;

   // one restoring step
   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = operand;
         res_in  = '0;
         bit_in  = TOP_BIT;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

// ----- rtl/aik_cordic.sv -----
// Vectoring CORDIC, one rotation per cycle: atan(b/a) for a >= 0.
// Depends on aik_pkg.
module aik_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [aik_pkg::CV_W-1:0]    vec_a,
   input  logic signed [aik_pkg::CV_W-1:0]    vec_b,
   output logic                               done,
   output logic signed [aik_pkg::PHASE_W-1:0] angle
);
   import aik_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic                      vert_ff, vert_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic signed [CV_W-1:0]    a_ff, a_in;
   logic signed [CV_W-1:0]    b_ff, b_in;
   logic signed [PHASE_W-1:0] ang_ff, ang_in;
   logic signed [CV_W-1:0]    da, db;

   always_comb begin
      da      = b_ff >>> step_ff;
      db      = a_ff >>> step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      vert_in = vert_ff;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      ang_in  = ang_ff;
      if (start) begin
         a_in    = vec_a;
         b_in    = vec_b;
         step_in = '0;
         busy_in = 1'b1;
         vert_in = (vec_a == '0);
         if (vec_a == '0) begin
            // vertical vector: answer known now, held for the full run
            // so that all units finish on the same cycle
            if (vec_b > 0) begin
               ang_in = HALF_PI;
            end else if (vec_b < 0) begin
               ang_in = -HALF_PI;
            end else begin
               ang_in = '0;
            end
         end else begin
            ang_in = '0;
         end
      end else if (busy_ff) begin
         if (!vert_ff) begin
            if (!b_ff[CV_W-1]) begin
               a_in   = a_ff + da;
               b_in   = b_ff - db;
               ang_in = ang_ff + atan_entry(step_ff);
            end else begin
               a_in   = a_ff - da;
               b_in   = b_ff + db;
               ang_in = ang_ff - atan_entry(step_ff);
            end
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(CORDIC_N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      ang_ff  <= ang_in;
      vert_ff <= vert_in;
   end

   assign done  = done_ff;
   assign angle = ang_ff;

endmodule

// ----- rtl/aik_back.sv -----
// Execution side: servo state, geometry sequencer and the result register.
// Depends on aik_pkg, aik_isqrt and aik_cordic.
module aik_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [aik_pkg::REACH_W-1:0]   reach,
   input  logic                          head_valid,
   input  aik_pkg::item_type             head,
   output logic                          head_pop,
   output logic                          rsp_valid,
   output aik_pkg::result_type           rsp,
   input  logic                          rsp_pop
);
   import aik_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SQUARE = 4'd1;
   localparam logic [3:0] ST_SUM    = 4'd2;
   localparam logic [3:0] ST_CHECK  = 4'd3;
   localparam logic [3:0] ST_SQRT   = 4'd4;
   localparam logic [3:0] ST_CORDIC = 4'd5;
   localparam logic [3:0] ST_MUL    = 4'd6;
   localparam logic [3:0] ST_PREP   = 4'd7;
   localparam logic [3:0] ST_STORE  = 4'd9;
   localparam logic [3:0] ST_EMIT   = 4'd10;

   localparam logic [1:0] IDX_BASE     = 2'd0;
   localparam logic [1:0] IDX_SHOULDER = 2'd1;
   localparam logic [1:0] IDX_ELBOW    = 2'd2;
   localparam logic [1:0] IDX_GRIP     = 2'd3;

   // degrees = (573200*s + K*2^30) / (10000*2^30)
   localparam logic signed [NUM_W-1:0] DEG_SCALE  = 56'sd573200;
   localparam logic signed [NUM_W-1:0] K_BASE     = 56'sd900000 <<< Q_SHIFT;
   localparam logic signed [NUM_W-1:0] K_SHOULDER = 56'sd800076 <<< Q_SHIFT;
   localparam logic signed [NUM_W-1:0] K_ELBOW    = -(56'sd76 <<< Q_SHIFT);
   localparam logic [QUO_W-1:0]        SAT_Q      = 26'd1810000;

   // divide by 10000 as multiply by ceil(2^35/10000), exact below 1810000
   localparam int                      RECIP_W     = 22;
   localparam int                      RECIP_SHIFT = 35;
   localparam int                      SCALED_W    = REM_W + RECIP_W;
   localparam logic [RECIP_W-1:0]      DEG_RECIP   = 22'd3435974;

   logic [3:0]                state_ff, state_in;
   logic [DEG_W-1:0]          pos_ff [4];
   logic [DEG_W-1:0]          pos_in [4];
   logic [DEG_W-1:0]          tgt_ff [4];
   logic [DEG_W-1:0]          tgt_in [4];
   logic                      unreach_ff, unreach_in;
   logic                      out_valid_ff, out_valid_in;
   result_type                out_ff, out_in;

   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [SUM_W-1:0]          xx_ff, xx_in, yy_ff, yy_in, zz_ff, zz_in;
   logic [SUM_W-1:0]          h2_ff, h2_in, r2_ff, r2_in;
   logic [RR2_W-1:0]          rr2_ff, rr2_in;
   logic [RR_W-1:0]           rr;
   logic [1:0]                idx_ff, idx_in;
   logic signed [NUM_W-1:0]   num_ff, num_in;
   logic [DEG_W-1:0]          quo_ff, quo_in;

   logic                      out_free;
   logic                      sq_start, co_start;
   logic                      sq_done_op, sq_done_ad, sq_done_h;
   logic                      co_done_a, co_done_b, co_done_c;
   logic [ROOT_W-1:0]         root_op, root_ad, root_h;
   logic signed [PHASE_W-1:0] ang_a, ang_b, ang_c;
   logic signed [COORD_W:0]   y_abs, x_signed;
   logic signed [S_W-1:0]     s_sel;
   logic signed [NUM_W-1:0]   k_sel, prod;
   logic [QUO_W-1:0]          q_whole;
   logic [SCALED_W-1:0]       scaled;
   logic                      all_settled;

   // square roots of r2, R2-r2 and h2, run side by side
   aik_isqrt u_sqrt_op (
      .clock(clock), .reset(reset), .start(sq_start),
      .operand(RAD_W'(r2_ff) << 16), .done(sq_done_op), .root(root_op)
   );
   aik_isqrt u_sqrt_ad (
      .clock(clock), .reset(reset), .start(sq_start),
      .operand((RAD_W'(rr2_ff) - RAD_W'(r2_ff)) << 16), .done(sq_done_ad), .root(root_ad)
   );
   aik_isqrt u_sqrt_h (
      .clock(clock), .reset(reset), .start(sq_start),
      .operand(RAD_W'(h2_ff) << 16), .done(sq_done_h), .root(root_h)
   );

   // the three arctangents: A, B and C
   assign y_abs    = y_ff[COORD_W-1] ? -(COORD_W+1)'(y_ff) : (COORD_W+1)'(y_ff);
   assign x_signed = y_ff[COORD_W-1] ? -(COORD_W+1)'(x_ff) : (COORD_W+1)'(x_ff);

   aik_cordic u_atan_a (
      .clock(clock), .reset(reset), .start(co_start),
      .vec_a(CV_W'({1'b0, root_ad})), .vec_b(CV_W'({1'b0, root_op})),
      .done(co_done_a), .angle(ang_a)
   );
   aik_cordic u_atan_b (
      .clock(clock), .reset(reset), .start(co_start),
      .vec_a(CV_W'({1'b0, root_h}) <<< 8), .vec_b(CV_W'(z_ff) <<< 16),
      .done(co_done_b), .angle(ang_b)
   );
   aik_cordic u_atan_c (
      .clock(clock), .reset(reset), .start(co_start),
      .vec_a(CV_W'(y_abs) <<< 16), .vec_b(CV_W'(x_signed) <<< 16),
      .done(co_done_c), .angle(ang_c)
   );

   // degree conversion operands
   always_comb begin
      case (idx_ff)
         IDX_BASE: begin
            s_sel = S_W'(ang_c);
            k_sel = K_BASE;
         end
         IDX_SHOULDER: begin
            s_sel = S_W'(ang_a) - S_W'(ang_b);
            k_sel = K_SHOULDER;
         end
         default: begin
            s_sel = S_W'(ang_a) + S_W'(ang_b);
            k_sel = K_ELBOW;
         end
      endcase
   end

   assign prod     = DEG_SCALE * s_sel;
   assign q_whole  = num_ff[NUM_W-1:Q_SHIFT];
   assign scaled   = SCALED_W'(q_whole[REM_W-1:0]) * SCALED_W'(DEG_RECIP);
   assign rr       = RR_W'(reach) << COORD_FRAC_BITS;
   assign out_free = !out_valid_ff || rsp_pop;
   assign head_pop = (state_ff == ST_IDLE) && head_valid && out_free;
   assign sq_start = (state_ff == ST_CHECK) && (r2_ff <= rr2_ff);
   assign co_start = (state_ff == ST_SQRT) && sq_done_op;

   always_comb begin
      all_settled = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (pos_ff[i] != tgt_ff[i]) begin
            all_settled = 1'b0;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      tgt_in     = tgt_ff;
      unreach_in = unreach_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      xx_in      = xx_ff;
      yy_in      = yy_ff;
      zz_in      = zz_ff;
      rr2_in     = rr2_ff;
      h2_in      = h2_ff;
      r2_in      = r2_ff;
      idx_in     = idx_ff;
      num_in     = num_ff;
      quo_in     = quo_ff;
      out_in     = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      case (state_ff)
         ST_IDLE: begin
            if (head_pop) begin
               unreach_in = 1'b0;
               state_in   = ST_EMIT;
               case (head.kind)
                  CMD_TARGET: begin
                     x_in     = head.x;
                     y_in     = head.y;
                     z_in     = head.z;
                     state_in = ST_SQUARE;
                  end
                  CMD_GRIP: tgt_in[IDX_GRIP] = head.grip;
                  CMD_TICK: begin
                     for (int i = 0; i < 4; i++) begin
                        if (pos_ff[i] < tgt_ff[i]) begin
                           pos_in[i] = pos_ff[i] + DEG_W'(1);
                        end else if (pos_ff[i] > tgt_ff[i]) begin
                           pos_in[i] = pos_ff[i] - DEG_W'(1);
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SQUARE: begin
            xx_in    = SUM_W'(x_ff) * SUM_W'(x_ff);
            yy_in    = SUM_W'(y_ff) * SUM_W'(y_ff);
            zz_in    = SUM_W'(z_ff) * SUM_W'(z_ff);
            rr2_in   = RR2_W'(rr) * RR2_W'(rr);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            h2_in    = xx_ff + yy_ff;
            r2_in    = xx_ff + yy_ff + zz_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (r2_ff > rr2_ff) begin
               unreach_in = 1'b1;
               state_in   = ST_EMIT;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_done_op) begin
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (co_done_a) begin
               idx_in   = IDX_BASE;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            num_in   = prod + k_sel;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            // negative clamps to 0, 181 or more clamps to 180
            state_in = ST_STORE;
            if (num_ff[NUM_W-1]) begin
               quo_in = '0;
            end else if (q_whole >= SAT_Q) begin
               quo_in = ANGLE_MAX;
            end else begin
               quo_in = scaled[RECIP_SHIFT +: DEG_W];
            end
         end
         ST_STORE: begin
            tgt_in[idx_ff] = quo_ff;
            if (idx_ff == IDX_ELBOW) begin
               state_in = ST_EMIT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            out_in.base        = pos_ff[IDX_BASE];
            out_in.shoulder    = pos_ff[IDX_SHOULDER];
            out_in.elbow       = pos_ff[IDX_ELBOW];
            out_in.grip        = pos_ff[IDX_GRIP];
            out_in.unreachable = unreach_ff;
            out_in.settled     = all_settled;
            out_valid_in       = 1'b1;
            state_in           = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         unreach_ff   <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            pos_ff[i] <= ANGLE_CENTER;
            tgt_ff[i] <= ANGLE_CENTER;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         unreach_ff   <= unreach_in;
         pos_ff       <= pos_in;
         tgt_ff       <= tgt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      xx_ff    <= xx_in;
      yy_ff    <= yy_in;
      zz_ff    <= zz_in;
      rr2_ff   <= rr2_in;
      h2_ff    <= h2_in;
      r2_ff    <= r2_in;
      idx_ff   <= idx_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // the root units finish together, and only while they are awaited
   a_sqrt_in_step: assert property (@(posedge clock) disable iff (reset)
      (sq_done_op || sq_done_ad || sq_done_h) |->
         (sq_done_op && sq_done_ad && sq_done_h && state_ff == ST_SQRT))
      else $error("square root units out of step");

   // arctangent results arrive only while the sequencer waits for them
   a_atan_in_step: assert property (@(posedge clock) disable iff (reset)
      (co_done_a || co_done_b || co_done_c) |-> state_ff == ST_CORDIC)
      else $error("unexpected arctangent completion");

   // the result slot was reserved at dispatch
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> !out_valid_ff)
      else $error("result overwritten before transfer");

   // servo positions never leave the legal range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff[0] <= ANGLE_MAX) && (pos_ff[1] <= ANGLE_MAX) &&
      (pos_ff[2] <= ANGLE_MAX) && (pos_ff[3] <= ANGLE_MAX))
      else $error("servo position above 180");

endmodule

// ----- rtl/arm_inverse_kinematics_slew.sv -----
// Arm inverse kinematics with servo slewing: one result per item. Gripper,
// tick and no-op items go from idle to emit. Target items: 22 square-root
// steps, 16 CORDIC rotations, then multiply, prepare and store states per
// angle for the degree conversion; an out-of-reach target goes from check
// to emit. One item runs at a time, the next is taken once the result slot
// is free; two more wait in the queue. Sync reset: servos 90, reach 160.
module arm_inverse_kinematics_slew (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [aik_pkg::CMD_W-1:0]          req_command,
   input  logic signed [aik_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [aik_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [aik_pkg::COORD_W-1:0] req_coord_z,
   input  logic [aik_pkg::DEG_W-1:0]          req_gripper_target,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [aik_pkg::DEG_W-1:0]          rsp_base_angle,
   output logic [aik_pkg::DEG_W-1:0]          rsp_shoulder_angle,
   output logic [aik_pkg::DEG_W-1:0]          rsp_elbow_angle,
   output logic [aik_pkg::DEG_W-1:0]          rsp_grip_angle,
   output logic                               rsp_unreachable,
   output logic                               rsp_settled,
   input  logic                               csr_write_en,
   input  logic [aik_pkg::REACH_W-1:0]        csr_write_data
);
   import aik_pkg::*;

   logic [REACH_W-1:0] reach_ff;
   logic               head_valid, head_pop, rsp_valid;
   item_type           head;
   result_type         rsp;

   // arm reach register
   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff <= REACH_RESET;
      end else if (csr_write_en) begin
         reach_ff <= csr_write_data;
      end
   end

   aik_front u_front (
      .clock(clock), .reset(reset),
      .push(req_push), .full(req_full),
      .command(req_command), .coord_x(req_coord_x), .coord_y(req_coord_y),
      .coord_z(req_coord_z), .gripper_target(req_gripper_target),
      .head_valid(head_valid), .head(head), .head_pop(head_pop)
   );

   aik_back u_back (
      .clock(clock), .reset(reset), .reach(reach_ff),
      .head_valid(head_valid), .head(head), .head_pop(head_pop),
      .rsp_valid(rsp_valid), .rsp(rsp), .rsp_pop(rsp_pop)
   );

   // result ports
   assign rsp_empty          = !rsp_valid;
   assign rsp_base_angle     = rsp.base;
   assign rsp_shoulder_angle = rsp.shoulder;
   assign rsp_elbow_angle    = rsp.elbow;
   assign rsp_grip_angle     = rsp.grip;
   assign rsp_unreachable    = rsp.unreachable;
   assign rsp_settled        = rsp.settled;

endmodule
